[sv/mbcr_pkg.sv]
// ============================================================================
// mbcr_pkg: shared definitions for the mesh box crop and remap block
// Codes, widths and the record types exchanged between front, queue and back.
// ============================================================================
package mbcr_pkg;

    localparam int MAX_POINTS_DEF        = 65536;
    localparam int MAX_CELL_VERTICES_DEF = 20;
    localparam int QUEUE_DEPTH           = 2;

    // Cell sizes and gather positions never exceed 32.
    localparam int SIZE_W = 6;

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_POINT  = 2'd1;
    localparam logic [1:0] ACT_VERTEX = 2'd2;

    localparam logic RK_POINT  = 1'b0;
    localparam logic RK_VERTEX = 1'b1;

    localparam logic [2:0] CFG_DIMENSIONS = 3'd0;
    localparam logic [2:0] CFG_X_LOW      = 3'd1;
    localparam logic [2:0] CFG_X_HIGH     = 3'd2;
    localparam logic [2:0] CFG_Y_LOW      = 3'd3;
    localparam logic [2:0] CFG_Y_HIGH     = 3'd4;
    localparam logic [2:0] CFG_Z_LOW      = 3'd5;
    localparam logic [2:0] CFG_Z_HIGH     = 3'd6;
    localparam logic [2:0] CFG_VPC        = 3'd7;

    typedef struct packed {
        logic               is_cell;
        logic               bank;
        logic [SIZE_W-1:0]  cell_size;
        logic [15:0]        new_index;
        logic [31:0]        x;
        logic [31:0]        y;
        logic [31:0]        z;
        logic [15:0]        cell_number;
        logic [16:0]        kept_count;
    } q_entry_t;

    typedef struct packed {
        logic               we;
        logic               bank;
        logic [SIZE_W-1:0]  pos;
        logic [15:0]        data;
    } gather_wr_t;

    typedef struct packed {
        logic rel;
        logic bank;
    } release_t;

endpackage

[sv/mesh_box_crop_remap.sv]
// ============================================================================
// mesh_box_crop_remap: crop a streamed mesh to an axis-aligned box
// Keeps points inside the box, renumbers them and remaps kept cells.
// ============================================================================
// Usage:
//   The input channel takes start, point and cell vertex items; a transfer
//   happens when in_valid and in_ready are both high. The output channel
//   carries kept points and the vertex runs of kept cells, one result per
//   transfer. The configuration channel is always ready and should only be
//   written while the block is idle.
//   Throughput is one input item per cycle while in_ready is high. A kept
//   cell of n vertices takes n output transfers, one vertex per cycle while
//   out_ready is high, with the next record issued back to back. The first
//   result passes the classify register (it also captures the point map
//   read), the queue, the run register, the gather bank read and the output
//   register before out_valid for it rises.
//   The point map is a single memory with one write port and one read port;
//   entries are trusted only below the current point count, so reset and
//   start items need no clearing pass. A stalled receiver fills the output,
//   gather read and run registers, then the queue; once the queue is full,
//   or a cell needs a gather bank that is still being read out, in_ready
//   drops. Reset returns the box to its widest setting, three dimensions
//   and eight vertices per cell.
module mesh_box_crop_remap #(
    parameter int MAX_POINTS        = mbcr_pkg::MAX_POINTS_DEF,
    parameter int MAX_CELL_VERTICES = mbcr_pkg::MAX_CELL_VERTICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic [15:0]         vertex_old_index,
    input  logic                last_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                result_kind,
    output logic [15:0]         new_index,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_z,
    output logic [15:0]         cell_number,
    output logic [16:0]         kept_count,
    output logic                last_of_run,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    // Configuration registers.
    logic [1:0]         dims_reg;
    logic signed [31:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic signed [31:0] z_low_reg, z_high_reg;
    logic [4:0]         vpc_reg;

    mbcr_pkg::q_entry_t   push_data, pop_data;
    mbcr_pkg::gather_wr_t gw;
    mbcr_pkg::release_t   rel;
    logic                 push_valid, push_ready, pop_valid, pop_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg   <= 2'd3;
            x_low_reg  <= 32'sh8000_0000;
            x_high_reg <= 32'sh7fff_ffff;
            y_low_reg  <= 32'sh8000_0000;
            y_high_reg <= 32'sh7fff_ffff;
            z_low_reg  <= 32'sh8000_0000;
            z_high_reg <= 32'sh7fff_ffff;
            vpc_reg    <= 5'd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mbcr_pkg::CFG_DIMENSIONS: dims_reg   <= cfg_data[1:0];
                mbcr_pkg::CFG_X_LOW:      x_low_reg  <= cfg_data;
                mbcr_pkg::CFG_X_HIGH:     x_high_reg <= cfg_data;
                mbcr_pkg::CFG_Y_LOW:      y_low_reg  <= cfg_data;
                mbcr_pkg::CFG_Y_HIGH:     y_high_reg <= cfg_data;
                mbcr_pkg::CFG_Z_LOW:      z_low_reg  <= cfg_data;
                mbcr_pkg::CFG_Z_HIGH:     z_high_reg <= cfg_data;
                mbcr_pkg::CFG_VPC:        vpc_reg    <= cfg_data[4:0];
            endcase
        end
    end

    // The front classifies items and owns the point map.
    mbcr_front #(
        .MAX_POINTS        (MAX_POINTS),
        .MAX_CELL_VERTICES (MAX_CELL_VERTICES)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .coord_x           (coord_x),
        .coord_y           (coord_y),
        .coord_z           (coord_z),
        .vertex_old_index  (vertex_old_index),
        .last_item         (last_item),
        .dimensions        (dims_reg),
        .x_low             (x_low_reg),
        .x_high            (x_high_reg),
        .y_low             (y_low_reg),
        .y_high            (y_high_reg),
        .z_low             (z_low_reg),
        .z_high            (z_high_reg),
        .vertices_per_cell (vpc_reg),
        .q_valid           (push_valid),
        .q_ready           (push_ready),
        .q_data            (push_data),
        .gw                (gw),
        .rel               (rel)
    );

    mbcr_queue #(
        .DEPTH      (mbcr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // The back expands each record into one or more output transfers.
    mbcr_back #(
        .MAX_CELL_VERTICES (MAX_CELL_VERTICES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .gw          (gw),
        .rel         (rel),
        .q_valid     (pop_valid),
        .q_ready     (pop_ready),
        .q_data      (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .new_index   (new_index),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .cell_number (cell_number),
        .kept_count  (kept_count),
        .last_of_run (last_of_run)
    );

endmodule

[sv/mbcr_queue.sv]
// ============================================================================
// mbcr_queue: short FIFO between front and back
// Holds classified result records so that each side can stall on its own.
// ============================================================================
module mbcr_queue #(
    parameter int DEPTH = mbcr_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  mbcr_pkg::q_entry_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output mbcr_pkg::q_entry_t pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mbcr_pkg::q_entry_t slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/mbcr_front.sv]
// ============================================================================
// mbcr_front: item intake, box test, point map and cell gathering
// Accepts items, keeps the old-to-new point map and classifies each item.
// ============================================================================
module mbcr_front #(
    parameter int MAX_POINTS        = mbcr_pkg::MAX_POINTS_DEF,
    parameter int MAX_CELL_VERTICES = mbcr_pkg::MAX_CELL_VERTICES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic signed [31:0]   coord_x,
    input  logic signed [31:0]   coord_y,
    input  logic signed [31:0]   coord_z,
    input  logic [15:0]          vertex_old_index,
    input  logic                 last_item,
    input  logic [1:0]           dimensions,
    input  logic signed [31:0]   x_low,
    input  logic signed [31:0]   x_high,
    input  logic signed [31:0]   y_low,
    input  logic signed [31:0]   y_high,
    input  logic signed [31:0]   z_low,
    input  logic signed [31:0]   z_high,
    input  logic [4:0]           vertices_per_cell,
    output logic                 q_valid,
    input  logic                 q_ready,
    output mbcr_pkg::q_entry_t   q_data,
    output mbcr_pkg::gather_wr_t gw,
    input  mbcr_pkg::release_t   rel
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int WW = (CW > 16) ? CW : 16;
    localparam int SW = mbcr_pkg::SIZE_W;
    localparam logic [1:0] KIND_NOP = 2'd3;

    // Point map: kept flag and compacted index per original point.
    logic [16:0] map_mem [MAX_POINTS];
    logic [16:0] rd_reg;

    logic [CW-1:0] point_counter_reg, point_counter_next;
    logic [CW-1:0] kept_counter_reg, kept_counter_next;

    logic               b_valid_reg;
    logic [1:0]         b_kind_reg;
    logic [31:0]        b_x_reg, b_y_reg, b_z_reg;
    logic [15:0]        b_new_index_reg;
    logic [CW-1:0]      b_kept_reg;
    logic               b_last_reg;
    logic               b_in_range_reg;

    logic [15:0]        cell_reg, cell_next;
    logic [SW-1:0]      pos_reg, pos_next;
    logic               all_reg, all_next;
    logic               bank_reg, bank_next;
    logic [1:0]         busy_reg, busy_next;

    logic               in_acc, pc_full, in_box, in_range;
    logic [WW-1:0]      old_ext, pc_ext;
    logic [SW-1:0]      n_eff, pos_cur, pos_inc;
    logic               v_ok, complete, all_now, push, b_go;

    assign in_acc  = in_valid && in_ready;
    assign pc_full = (point_counter_reg == CW'(MAX_POINTS));
    assign old_ext = WW'(vertex_old_index);
    assign pc_ext  = WW'(point_counter_reg);
    assign in_range = (old_ext < pc_ext);

    always_comb
    begin
        in_box = (coord_x >= x_low) && (coord_x <= x_high);
        if (dimensions >= 2'd2)
        begin
            in_box = in_box && (coord_y >= y_low) && (coord_y <= y_high);
        end
        if (dimensions == 2'd3)
        begin
            in_box = in_box && (coord_z >= z_low) && (coord_z <= z_high);
        end
    end

    always_comb
    begin
        if (vertices_per_cell == 5'd0)
        begin
            n_eff = SW'(1);
        end
        else if (SW'(vertices_per_cell) > SW'(MAX_CELL_VERTICES))
        begin
            n_eff = SW'(MAX_CELL_VERTICES);
        end
        else
        begin
            n_eff = SW'(vertices_per_cell);
        end
    end

    assign pos_cur  = (pos_reg >= n_eff) ? '0 : pos_reg;
    assign pos_inc  = pos_cur + 1'b1;
    assign v_ok     = b_in_range_reg && rd_reg[16];
    assign complete = (pos_inc == n_eff);
    assign all_now  = all_reg && v_ok;
    assign push     = (b_kind_reg == mbcr_pkg::ACT_POINT)
                   || ((b_kind_reg == mbcr_pkg::ACT_VERTEX) && complete && all_now);

    always_comb
    begin
        priority if (b_kind_reg == mbcr_pkg::ACT_VERTEX)
        begin
            b_go = b_valid_reg && !busy_reg[bank_reg] && (!push || q_ready);
        end
        else if (b_kind_reg == mbcr_pkg::ACT_POINT)
        begin
            b_go = b_valid_reg && q_ready;
        end
        else
        begin
            b_go = b_valid_reg;
        end
    end

    assign in_ready = !b_valid_reg || b_go;
    assign q_valid  = b_valid_reg && push && b_go;

    always_comb
    begin
        q_data.is_cell     = (b_kind_reg == mbcr_pkg::ACT_VERTEX);
        q_data.bank        = bank_reg;
        q_data.cell_size   = q_data.is_cell ? n_eff : SW'(1);
        q_data.new_index   = b_new_index_reg;
        q_data.x           = q_data.is_cell ? '0 : b_x_reg;
        q_data.y           = q_data.is_cell ? '0 : b_y_reg;
        q_data.z           = q_data.is_cell ? '0 : b_z_reg;
        q_data.cell_number = q_data.is_cell ? cell_reg : '0;
        q_data.kept_count  = 17'(b_kept_reg);
    end

    always_comb
    begin
        gw.we   = b_go && (b_kind_reg == mbcr_pkg::ACT_VERTEX) && v_ok;
        gw.bank = bank_reg;
        gw.pos  = pos_cur;
        gw.data = rd_reg[15:0];
    end

    always_comb
    begin
        point_counter_next = point_counter_reg;
        kept_counter_next  = kept_counter_reg;
        if (in_acc)
        begin
            if (action == mbcr_pkg::ACT_START)
            begin
                point_counter_next = '0;
                kept_counter_next  = '0;
            end
            else if ((action == mbcr_pkg::ACT_POINT) && !pc_full)
            begin
                point_counter_next = point_counter_reg + 1'b1;
                if (in_box)
                begin
                    kept_counter_next = kept_counter_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        cell_next = cell_reg;
        pos_next  = pos_reg;
        all_next  = all_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (rel.rel)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (b_go && (b_kind_reg == mbcr_pkg::ACT_START))
        begin
            cell_next = '0;
            pos_next  = '0;
            all_next  = 1'b1;
        end
        else if (b_go && (b_kind_reg == mbcr_pkg::ACT_VERTEX))
        begin
            if (complete)
            begin
                cell_next = cell_reg + 1'b1;
                pos_next  = '0;
                all_next  = 1'b1;
                if (push)
                begin
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = !bank_reg;
                end
            end
            else if (b_last_reg)
            begin
                cell_next = cell_reg + 1'b1;
                pos_next  = '0;
                all_next  = 1'b1;
            end
            else
            begin
                pos_next = pos_inc;
                all_next = all_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_counter_reg <= '0;
            kept_counter_reg  <= '0;
            b_valid_reg       <= 1'b0;
            b_kind_reg        <= KIND_NOP;
            cell_reg          <= '0;
            pos_reg           <= '0;
            all_reg           <= 1'b1;
            bank_reg          <= 1'b0;
            busy_reg          <= '0;
        end
        else
        begin
            point_counter_reg <= point_counter_next;
            kept_counter_reg  <= kept_counter_next;
            cell_reg          <= cell_next;
            pos_reg           <= pos_next;
            all_reg           <= all_next;
            bank_reg          <= bank_next;
            busy_reg          <= busy_next;
            if (in_acc)
            begin
                b_valid_reg <= 1'b1;
                if ((action == mbcr_pkg::ACT_POINT) && (pc_full || !in_box))
                begin
                    b_kind_reg <= KIND_NOP;
                end
                else
                begin
                    b_kind_reg <= action;
                end
            end
            else if (b_go)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            b_x_reg         <= coord_x;
            b_y_reg         <= coord_y;
            b_z_reg         <= coord_z;
            b_new_index_reg <= 16'(kept_counter_reg);
            b_kept_reg      <= (action == mbcr_pkg::ACT_POINT) ? kept_counter_reg + 1'b1
                                                               : kept_counter_reg;
            b_last_reg      <= last_item;
            b_in_range_reg  <= in_range;
        end
        if (in_acc && (action == mbcr_pkg::ACT_POINT) && !pc_full)
        begin
            map_mem[point_counter_reg[AW-1:0]] <= {in_box, 16'(kept_counter_reg)};
        end
        if (in_acc && (action == mbcr_pkg::ACT_VERTEX))
        begin
            rd_reg <= map_mem[old_ext[AW-1:0]];
        end
    end

endmodule

[sv/mbcr_back.sv]
// ============================================================================
// mbcr_back: result sequencer
// Pops records, expands kept cells into vertex runs and drives the output.
// ============================================================================
module mbcr_back #(
    parameter int MAX_CELL_VERTICES = mbcr_pkg::MAX_CELL_VERTICES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbcr_pkg::gather_wr_t gw,
    output mbcr_pkg::release_t   rel,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  mbcr_pkg::q_entry_t   q_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 result_kind,
    output logic [15:0]          new_index,
    output logic signed [31:0]   out_x,
    output logic signed [31:0]   out_y,
    output logic signed [31:0]   out_z,
    output logic [15:0]          cell_number,
    output logic [16:0]          kept_count,
    output logic                 last_of_run
);
    localparam int GD = 2 * MAX_CELL_VERTICES;
    localparam int GA = $clog2(GD);
    localparam int SW = mbcr_pkg::SIZE_W;

    // Two gather banks, one per cell in flight.
    logic [15:0] gather_mem [GD];
    logic [15:0] rd_reg;

    logic               run_valid_reg;
    mbcr_pkg::q_entry_t run_reg;
    logic [SW-1:0]      k_reg;

    logic               p_valid_reg;
    mbcr_pkg::q_entry_t p_reg;
    logic               p_last_reg;

    logic               o_valid_reg;
    logic               o_kind_reg;
    logic [15:0]        o_index_reg;
    logic [31:0]        o_x_reg, o_y_reg, o_z_reg;
    logic [15:0]        o_cell_reg;
    logic [16:0]        o_kept_reg;
    logic               o_last_reg;

    logic               p_move, can_issue, issue, issue_last, do_pop;
    logic [GA-1:0]      wa, ra;

    assign p_move     = p_valid_reg && (!o_valid_reg || out_ready);
    assign can_issue  = !p_valid_reg || p_move;
    assign issue      = run_valid_reg && can_issue;
    assign issue_last = ((k_reg + 1'b1) == run_reg.cell_size);
    assign q_ready    = !run_valid_reg || (issue && issue_last);
    assign do_pop     = q_valid && q_ready;

    assign wa = gw.bank ? GA'(MAX_CELL_VERTICES) + GA'(gw.pos) : GA'(gw.pos);
    assign ra = run_reg.bank ? GA'(MAX_CELL_VERTICES) + GA'(k_reg) : GA'(k_reg);

    assign rel.rel  = issue && issue_last && run_reg.is_cell;
    assign rel.bank = run_reg.bank;

    always_ff @(posedge clk)
    begin
        if (gw.we)
        begin
            gather_mem[wa] <= gw.data;
        end
        if (issue && run_reg.is_cell)
        begin
            rd_reg <= gather_mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            k_reg         <= '0;
            p_valid_reg   <= 1'b0;
            o_valid_reg   <= 1'b0;
        end
        else
        begin
            if (do_pop)
            begin
                run_valid_reg <= 1'b1;
                k_reg         <= '0;
            end
            else if (issue && issue_last)
            begin
                run_valid_reg <= 1'b0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (issue)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_move)
            begin
                p_valid_reg <= 1'b0;
            end
            if (p_move)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            run_reg <= q_data;
        end
        if (issue)
        begin
            p_reg      <= run_reg;
            p_last_reg <= issue_last;
        end
        if (p_move)
        begin
            o_kind_reg  <= p_reg.is_cell ? mbcr_pkg::RK_VERTEX : mbcr_pkg::RK_POINT;
            o_index_reg <= p_reg.is_cell ? rd_reg : p_reg.new_index;
            o_x_reg     <= p_reg.x;
            o_y_reg     <= p_reg.y;
            o_z_reg     <= p_reg.z;
            o_cell_reg  <= p_reg.cell_number;
            o_kept_reg  <= p_reg.kept_count;
            o_last_reg  <= p_reg.is_cell && p_last_reg;
        end
    end

    assign out_valid   = o_valid_reg;
    assign result_kind = o_kind_reg;
    assign new_index   = o_index_reg;
    assign out_x       = o_x_reg;
    assign out_y       = o_y_reg;
    assign out_z       = o_z_reg;
    assign cell_number = o_cell_reg;
    assign kept_count  = o_kept_reg;
    assign last_of_run = o_last_reg;

endmodule

[sv/mbcr_checker.sv]
// ============================================================================
// mbcr_checker: port-level checks for the mesh box crop block
// Watches the top-level ports and is bound to every instance of it.
// ============================================================================
module mbcr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        result_kind,
    input logic [15:0] new_index,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic [31:0] out_z,
    input logic [15:0] cell_number,
    input logic [16:0] kept_count,
    input logic        last_of_run
);
    // A stalled result keeps its index, kind and kept count.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_index)
                                 && $stable(result_kind) && $stable(kept_count))
        else $error("output changed while stalled");

    // Point results carry no cell information.
    a_point_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == mbcr_pkg::RK_POINT)
            |-> (cell_number == 16'd0) && !last_of_run)
        else $error("point result with cell fields");

    // Vertex results carry no coordinates.
    a_vertex_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == mbcr_pkg::RK_VERTEX)
            |-> (out_x == 32'd0) && (out_y == 32'd0) && (out_z == 32'd0))
        else $error("vertex result with coordinates");

    // A vertex that does not end its run is followed by a vertex of the same cell.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (result_kind == mbcr_pkg::RK_VERTEX) && !last_of_run
            ##1 out_valid |-> (result_kind == mbcr_pkg::RK_VERTEX)
                           && (cell_number == $past(cell_number)))
        else $error("vertex run broken");

endmodule

bind mesh_box_crop_remap mbcr_checker u_mbcr_checker (.*);

[dv/mesh_box_crop_remap_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// mesh_box_crop_remap_tb: self-checking bench for the mesh box crop block
// Streams start, point, cell vertex and unused action items under random idling on both
// channels. A scoreboard predicts every kept point and every remapped cell run
// and compares each output transfer field by field, oldest result first.
// ============================================================================
module mesh_box_crop_remap_tb;

    localparam int  PERIOD      = 8;
    localparam int  MAP_SIZE    = 65536;
    localparam int  CELL_LIMIT  = 20;
    localparam int  TARGET      = 420;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // One output transfer as the block should present it.
    typedef struct {
        logic               kind;
        logic [15:0]        index;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        cell_no;
        logic [16:0]        kept;
        logic               last;
    } crop_result_t;

    // Scoreboard: holds its own copy of the registers and the crop state and
    // turns every accepted input transfer into the results it should cause.
    class crop_scoreboard;
        logic [1:0]         dims;
        logic signed [31:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
        logic [4:0]         vpc;
        logic [15:0]        remap[int];
        int                 kept_points[$];
        int unsigned        point_count;
        int unsigned        kept_total;
        logic [15:0]        cell_count;
        int unsigned        gather_pos;
        bit                 all_kept;
        logic [15:0]        gather[CELL_LIMIT];
        crop_result_t       expected[$];
        int                 errors;

        function new();
            dims = 2'd3;
            x_lo = 32'sh8000_0000; x_hi = 32'sh7fff_ffff;
            y_lo = 32'sh8000_0000; y_hi = 32'sh7fff_ffff;
            z_lo = 32'sh8000_0000; z_hi = 32'sh7fff_ffff;
            vpc = 5'd8;
            errors = 0;
            clear_crop();
        endfunction

        function void clear_crop();
            remap.delete();
            kept_points.delete();
            point_count = 0;
            kept_total = 0;
            cell_count = 0;
            gather_pos = 0;
            all_kept = 1;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                mbcr_pkg::CFG_DIMENSIONS: dims = data[1:0];
                mbcr_pkg::CFG_X_LOW:      x_lo = data;
                mbcr_pkg::CFG_X_HIGH:     x_hi = data;
                mbcr_pkg::CFG_Y_LOW:      y_lo = data;
                mbcr_pkg::CFG_Y_HIGH:     y_hi = data;
                mbcr_pkg::CFG_Z_LOW:      z_lo = data;
                mbcr_pkg::CFG_Z_HIGH:     z_hi = data;
                mbcr_pkg::CFG_VPC:        vpc = data[4:0];
                default:                  ;
            endcase
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void note_input(logic [1:0] act, logic signed [31:0] cx,
                                 logic signed [31:0] cy, logic signed [31:0] cz,
                                 logic [15:0] old_index, logic last_item);
            crop_result_t r;
            bit           in_box;
            int unsigned  n;
            int unsigned  pos;
            int unsigned  k;
            case (act)
                mbcr_pkg::ACT_START: clear_crop();
                mbcr_pkg::ACT_POINT:
                begin
                    if (point_count >= MAP_SIZE)
                        return;
                    in_box = cx >= x_lo && cx <= x_hi;
                    if (dims >= 2)
                        in_box = in_box && cy >= y_lo && cy <= y_hi;
                    if (dims == 3)
                        in_box = in_box && cz >= z_lo && cz <= z_hi;
                    if (in_box)
                    begin
                        remap[point_count] = kept_total[15:0];
                        kept_points.insert(kept_points.size(), int'(point_count));
                        r.kind = mbcr_pkg::RK_POINT;
                        r.index = kept_total[15:0];
                        kept_total++;
                        r.x = cx; r.y = cy; r.z = cz;
                        r.cell_no = '0;
                        r.kept = kept_total[16:0];
                        r.last = 1'b0;
                        expected.insert(expected.size(), r);
                    end
                    point_count++;
                end
                mbcr_pkg::ACT_VERTEX:
                begin
                    n = (vpc == 0) ? 1 : (vpc > CELL_LIMIT) ? CELL_LIMIT : vpc;
                    // A size that shrank while a cell was half gathered
                    // restarts the gather.
                    pos = (gather_pos >= n) ? 0 : gather_pos;
                    if (remap.exists(int'(old_index)))
                        gather[pos] = remap[int'(old_index)];
                    else
                        all_kept = 0;
                    pos++;
                    if (pos == n || last_item)
                    begin
                        if (pos == n && all_kept)
                        begin
                            for (k = 0; k < n; k++)
                            begin
                                r.kind = mbcr_pkg::RK_VERTEX;
                                r.index = gather[k];
                                r.x = '0; r.y = '0; r.z = '0;
                                r.cell_no = cell_count;
                                r.kept = kept_total[16:0];
                                r.last = (k + 1 == n);
                                expected.insert(expected.size(), r);
                            end
                        end
                        cell_count++;
                        pos = 0;
                        all_kept = 1;
                    end
                    gather_pos = pos;
                end
                default: ;
            endcase
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(crop_result_t got);
            crop_result_t want;
            if (expected.size() == 0)
            begin
                report("unexpected result, index", got.index, 0);
                return;
            end
            want = expected.pop_front();
            if (got.kind !== want.kind)       report("result_kind", got.kind, want.kind);
            if (got.index !== want.index)     report("new_index", got.index, want.index);
            if (got.x !== want.x)             report("out_x", got.x, want.x);
            if (got.y !== want.y)             report("out_y", got.y, want.y);
            if (got.z !== want.z)             report("out_z", got.z, want.z);
            if (got.cell_no !== want.cell_no) report("cell_number", got.cell_no, want.cell_no);
            if (got.kept !== want.kept)       report("kept_count", got.kept, want.kept);
            if (got.last !== want.last)       report("last_of_run", got.last, want.last);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         action;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [15:0]        vertex_old_index;
    logic               last_item;
    logic               out_valid;
    logic               out_ready;
    logic               result_kind;
    logic [15:0]        new_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [15:0]        cell_number;
    logic [16:0]        kept_count;
    logic               last_of_run;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    crop_scoreboard     sb;
    int                 cycles;
    int                 items_sent;
    // Box of the current phase, used to aim points at its edges.
    logic signed [31:0] box_lo[3];
    logic signed [31:0] box_hi[3];

    mesh_box_crop_remap u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .coord_z          (coord_z),
        .vertex_old_index (vertex_old_index),
        .last_item        (last_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .new_index        (new_index),
        .out_x            (out_x),
        .out_y            (out_y),
        .out_z            (out_z),
        .cell_number      (cell_number),
        .kept_count       (kept_count),
        .last_of_run      (last_of_run),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial clk = 1'b0;
    always #(PERIOD / 2) clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output side: sample each transfer at the edge, then pick the next
    // ready level. Stalls come in runs so that they land on every phase
    // of a cell run.
    initial
    begin : receiver
        crop_result_t got;
        int           stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.kind    = result_kind;
                got.index   = new_index;
                got.x       = out_x;
                got.y       = out_y;
                got.z       = out_z;
                got.cell_no = cell_number;
                got.kept    = kept_count;
                got.last    = last_of_run;
                sb.check_result(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_length();
            end
        end
    end

    // Present one input item and hold it until the transfer happens. Valid is
    // left high afterwards so that back-to-back items need no second update
    // of it in the same step.
    task automatic send_item(logic [1:0] act, logic signed [31:0] cx,
                             logic signed [31:0] cy, logic signed [31:0] cz,
                             logic [15:0] old_index, logic last);
        int gap;
        gap = idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action           <= act;
        coord_x          <= cx;
        coord_y          <= cy;
        coord_z          <= cz;
        vertex_old_index <= old_index;
        last_item        <= last;
        in_valid         <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_input(act, cx, cy, cz, old_index, last);
        items_sent++;
    endtask

    task automatic stop_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every predicted result has come out, then a little longer,
    // since items without a result may still be in the pipeline.
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Valid stays high after a write so that back-to-back writes need no
    // second update of it in the same step; cfg_stop lowers it.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic cfg_stop();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_box(logic [1:0] dims, logic [4:0] vpc);
        write_reg(mbcr_pkg::CFG_DIMENSIONS, {30'd0, dims});
        write_reg(mbcr_pkg::CFG_X_LOW, box_lo[0]);
        write_reg(mbcr_pkg::CFG_X_HIGH, box_hi[0]);
        write_reg(mbcr_pkg::CFG_Y_LOW, box_lo[1]);
        write_reg(mbcr_pkg::CFG_Y_HIGH, box_hi[1]);
        write_reg(mbcr_pkg::CFG_Z_LOW, box_lo[2]);
        write_reg(mbcr_pkg::CFG_Z_HIGH, box_hi[2]);
        write_reg(mbcr_pkg::CFG_VPC, {27'd0, vpc});
        cfg_stop();
    endtask

    // Coordinate for one axis: mostly close to an edge of the box so that
    // the inclusive compare is hit from both sides, sometimes anywhere.
    function automatic logic signed [31:0] pick_coord(int axis);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return $urandom;
        if (roll < 6)
            return box_lo[axis] + $signed($urandom_range(0, 6)) - 32'sd3;
        if (roll < 9)
            return box_hi[axis] + $signed($urandom_range(0, 6)) - 32'sd3;
        return box_lo[axis] + (box_hi[axis] - box_lo[axis]) / 2;
    endfunction

    // Vertex index: mostly a point kept in this crop, else any index.
    function automatic logic [15:0] pick_vertex();
        if (sb.kept_points.size() != 0 && $urandom_range(0, 9) != 0)
            return 16'(sb.kept_points[$urandom_range(0, sb.kept_points.size() - 1)]);
        return 16'($urandom_range(0, MAP_SIZE - 1));
    endfunction

    // New random box for one axis: narrow, wide open, or empty.
    task automatic pick_axis(int axis);
        logic signed [31:0] centre;
        int                 roll;
        roll = $urandom_range(0, 9);
        centre = $urandom;
        if (roll < 6)
        begin
            box_lo[axis] = centre - $signed($urandom_range(0, 60000));
            box_hi[axis] = box_lo[axis] + $signed($urandom_range(0, 200000));
        end
        else if (roll < 8)
        begin
            box_lo[axis] = 32'sh8000_0000;
            box_hi[axis] = 32'sh7fff_ffff;
        end
        else
        begin
            // Low bound above high bound keeps nothing.
            box_hi[axis] = centre;
            box_lo[axis] = centre + 32'sd1 + $signed($urandom_range(0, 100));
        end
    endtask

    task automatic send_point(logic last);
        send_item(mbcr_pkg::ACT_POINT, pick_coord(0), pick_coord(1), pick_coord(2),
                  16'd0, last);
    endtask

    initial
    begin : stimulus
        int              phase;
        int              i;
        int              n_points;
        int              n_vertices;
        int              roll;
        logic [4:0]      vpc;
        logic [1:0]      dims;
        sb = new();
        cycles = 0;
        items_sent = 0;
        rst_n = 1'b0;
        in_valid <= 1'b0;
        action <= mbcr_pkg::ACT_START;
        coord_x <= '0;
        coord_y <= '0;
        coord_z <= '0;
        vertex_old_index <= '0;
        last_item <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= mbcr_pkg::CFG_DIMENSIONS;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: widest box, three axes, cells of eight.
        send_item(mbcr_pkg::ACT_START, 0, 0, 0, 16'd0, 1'b0);
        send_item(mbcr_pkg::ACT_POINT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  16'd0, 1'b0);
        send_item(mbcr_pkg::ACT_POINT, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                  16'd0, 1'b0);
        send_item(mbcr_pkg::ACT_POINT, 32'sh0000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                  16'hffff, 1'b1);
        // An unused action code must leave no trace.
        send_item(ACT_UNUSED, 32'sh1234_5678, 0, 0, 16'd1, 1'b1);
        for (i = 0; i < 8; i++)
            send_item(mbcr_pkg::ACT_VERTEX, 0, 0, 0, 16'(i % 3), 1'b0);
        // A cell that refers to a point never seen is dropped.
        for (i = 0; i < 8; i++)
            send_item(mbcr_pkg::ACT_VERTEX, 0, 0, 0, (i == 5) ? 16'hffff : 16'd1, 1'b0);
        // A cell cut short by the last flag is dropped and still counted.
        send_item(mbcr_pkg::ACT_VERTEX, 0, 0, 0, 16'd2, 1'b1);
        stop_input();
        drain();

        // Directed: zero dimensions means x only, zero cell size means one.
        box_lo[0] = -32'sd100; box_hi[0] = 32'sd100;
        box_lo[1] = 32'sd5;    box_hi[1] = 32'sd5;
        box_lo[2] = 32'sd7;    box_hi[2] = 32'sd6;
        write_box(2'd0, 5'd0);
        send_item(mbcr_pkg::ACT_START, 0, 0, 0, 16'd0, 1'b0);
        send_item(mbcr_pkg::ACT_POINT, -32'sd100, 32'sd99, 32'sd0, 16'd0, 1'b0);
        send_item(mbcr_pkg::ACT_POINT, 32'sd100, -32'sd9, 32'sd0, 16'd0, 1'b0);
        send_item(mbcr_pkg::ACT_POINT, -32'sd101, 32'sd5, 32'sd7, 16'd0, 1'b0);
        send_item(mbcr_pkg::ACT_POINT, 32'sd101, 32'sd5, 32'sd7, 16'd0, 1'b1);
        for (i = 0; i < 4; i++)
            send_item(mbcr_pkg::ACT_VERTEX, 0, 0, 0, 16'(i), 1'b0);
        stop_input();
        drain();

        // Random phases: a new box and cell size, a crop with random content,
        // now and then noise among the vertices.
        phase = 0;
        while (items_sent < TARGET)
        begin
            dims = 2'($urandom_range(0, 3));
            for (i = 0; i < 3; i++)
                pick_axis(i);
            roll = $urandom_range(0, 9);
            vpc = (roll < 6) ? 5'($urandom_range(1, 6)) :
                  (roll == 6) ? 5'd20 : (roll == 7) ? 5'd31 :
                  (roll == 8) ? 5'd0 : 5'($urandom_range(7, 19));
            write_box(dims, vpc);
            // Every other phase keeps the previous crop, so a shrunk cell
            // size can meet a half-gathered cell.
            if (phase % 2 == 0)
                send_item(mbcr_pkg::ACT_START, 0, 0, 0, 16'd0, 1'b0);
            n_points = $urandom_range(10, 40);
            for (i = 0; i < n_points; i++)
                send_point($urandom_range(0, 9) == 0);
            n_vertices = $urandom_range(10, 40);
            for (i = 0; i < n_vertices; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    send_item(ACT_UNUSED, $urandom, $urandom, $urandom,
                              16'($urandom), 1'($urandom_range(0, 1)));
                else if (roll < 6)
                    send_point(1'b0);
                else
                    send_item(mbcr_pkg::ACT_VERTEX, $urandom, $urandom, $urandom,
                              pick_vertex(), $urandom_range(0, 19) == 0);
            end
            stop_input();
            drain();
            phase++;
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
